[hdl/srk_pkg.sv]
// shared types and constants for the sparse row kernel
package srk_pkg;

   // action codes
   typedef enum logic [3:0] {
      ACT_ROW_START = 4'd0,
      ACT_ENTRY     = 4'd1,
      ACT_VECTOR    = 4'd2,
      ACT_RHS       = 4'd3,
      ACT_MULTIPLY  = 4'd4,
      ACT_RESIDUAL  = 4'd5,
      ACT_FWD_GS    = 4'd6,
      ACT_BWD_GS    = 4'd7,
      ACT_JACOBI    = 4'd8,
      ACT_READ_VEC  = 4'd9
   } action_type;

   // result status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_ZERO_DIAG = 2'd1;
   localparam logic [1:0] STATUS_RANGE     = 2'd2;

   // damping factor, 30 fraction bits
   localparam logic [31:0] OMEGA_RAW  = 32'd715827811;
   localparam int          OMEGA_FRAC = 30;

   // field widths
   localparam int ACTION_W = 4;
   localparam int POS_W    = 13;
   localparam int COL_W    = 10;
   localparam int DATA_W   = 32;
   localparam int ROW_W    = 10;
   localparam int CNT_W    = 11;
   localparam int ACC_W    = 64;

   // one classified item handed from front to back
   typedef struct packed {
      action_type          action;
      logic [POS_W-1:0]    position;
      logic [COL_W-1:0]    column;
      logic [DATA_W-1:0]   data_word;
      logic                in_range;
   } work_type;

endpackage

[hdl/srk_front.sv]
// front end: accepts items, checks row range and queues them for the back end
module srk_front
   import srk_pkg::*;
#(
   parameter int MAX_ROWS = 1024,
   parameter int DEPTH    = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [CNT_W-1:0]     row_count,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [ACTION_W-1:0]  req_action,
   input  logic [POS_W-1:0]     req_position,
   input  logic [COL_W-1:0]     req_column,
   input  logic [DATA_W-1:0]    req_data_word,
   output logic                 work_valid,
   input  logic                 work_ready,
   output work_type             work_item
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   work_type          queue_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]    fill_ff;
   work_type          classified;
   logic              push, pop;

   // range check against the configured and physical row limits
   always_comb begin
      classified.action    = action_type'(req_action);
      classified.position  = req_position;
      classified.column    = req_column;
      classified.data_word = req_data_word;
      classified.in_range  = ({{(32-POS_W){1'b0}}, req_position} < 32'(MAX_ROWS)) &&
                             ({{(POS_W-CNT_W){1'b0}}, row_count} > req_position);
   end

   assign req_ready  = (fill_ff != (PTR_W+1)'(DEPTH));
   assign work_valid = (fill_ff != '0);
   assign work_item  = queue_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = work_valid && work_ready;

   // queue storage
   always_ff @(posedge clock) begin
      if (push) queue_ff[wr_ptr_ff] <= classified;
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
         fill_ff <= fill_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
      end
   end
endmodule

[hdl/srk_divider.sv]
// restoring divider: 64-bit signed dividend by 64-bit signed divisor, saturated to 32 bits
module srk_divider
   import srk_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [ACC_W-1:0]   dividend,
   input  logic [ACC_W-1:0]   divisor,
   output logic               done,
   output logic [DATA_W-1:0]  quotient
);
   logic [ACC_W-1:0]  num_ff, den_ff, rem_ff, quo_ff;
   logic              neg_ff, busy_ff, done_ff;
   logic [6:0]        count_ff;
   logic [ACC_W:0]    trial;
   logic [ACC_W-1:0]  rem_shift;
   logic [DATA_W-1:0] sat_q;

   // one quotient bit a cycle
   assign rem_shift = {rem_ff[ACC_W-2:0], num_ff[ACC_W-1]};
   assign trial     = {1'b0, rem_shift} - {1'b0, den_ff};

   // sign and saturation of the finished magnitude
   always_comb begin
      if (!neg_ff) begin
         sat_q = (quo_ff > 64'h7fff_ffff) ? 32'h7fff_ffff : quo_ff[DATA_W-1:0];
      end else begin
         sat_q = (quo_ff >= 64'h8000_0000) ? 32'h8000_0000 : (~quo_ff[DATA_W-1:0] + 1'b1);
      end
   end

   assign done     = done_ff;
   assign quotient = sat_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= 7'd0;
            num_ff   <= dividend[ACC_W-1] ? (~dividend + 1'b1) : dividend;
            den_ff   <= divisor[ACC_W-1] ? (~divisor + 1'b1) : divisor;
            neg_ff   <= dividend[ACC_W-1] ^ divisor[ACC_W-1];
            rem_ff   <= '0;
            quo_ff   <= '0;
         end else if (busy_ff) begin
            num_ff <= {num_ff[ACC_W-2:0], 1'b0};
            if (!trial[ACC_W]) begin
               rem_ff <= trial[ACC_W-1:0];
               quo_ff <= {quo_ff[ACC_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_shift;
               quo_ff <= {quo_ff[ACC_W-2:0], 1'b0};
            end
            count_ff <= count_ff + 1'b1;
            if (count_ff == 7'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end
endmodule

[hdl/srk_back.sv]
// back end: stores, row walk sequencer, multiply-accumulate and result register
module srk_back
   import srk_pkg::*;
#(
   parameter int MAX_ROWS    = 1024,
   parameter int MAX_ENTRIES = 8192,
   parameter int FRAC_BITS   = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               work_valid,
   output logic               work_ready,
   input  work_type           work_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [ROW_W-1:0]   rsp_row,
   output logic [DATA_W-1:0]  rsp_result_value,
   output logic [1:0]         rsp_status
);
   localparam int RA_W = $clog2(MAX_ROWS);
   localparam int RS_W = $clog2(MAX_ROWS + 1);
   localparam int EA_W = $clog2(MAX_ENTRIES);
   localparam int EP_W = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_BEGIN, ST_END, ST_DIAG, ST_PREP, ST_FETCH, ST_VREAD,
      ST_MUL, ST_ACC, ST_FINISH, ST_DIV_MUL, ST_DIV, ST_WRITE, ST_OUT
   } state_type;

   // stores
   logic [EP_W-1:0]   row_start_mem [MAX_ROWS+1];
   logic [COL_W-1:0]  column_mem    [MAX_ENTRIES];
   logic [DATA_W-1:0] value_mem     [MAX_ENTRIES];
   logic [DATA_W-1:0] vector_mem    [MAX_ROWS];
   logic [DATA_W-1:0] rhs_mem       [MAX_ROWS];

   state_type         state_ff;
   work_type          item_ff;
   logic [EP_W-1:0]   rs_rd_ff, begin_ff, end_ff, k_ff;
   logic [COL_W-1:0]  col_rd_ff;
   logic [DATA_W-1:0] val_rd_ff, vec_rd_ff, rhs_rd_ff, xr_ff, diag_ff, coef_ff;
   logic              use_ff, col_ok_ff;
   logic signed [ACC_W-1:0] prod_ff, acc_ff;
   logic [ACC_W-1:0]  div_num_ff, div_den_ff;
   logic              div_start_ff;
   logic              div_done;
   logic [DATA_W-1:0] div_q;
   logic [DATA_W-1:0] res_value_ff;
   logic [1:0]        res_status_ff;
   logic              rsp_valid_ff;
   logic [ROW_W-1:0]  rsp_row_ff;
   logic [DATA_W-1:0] rsp_value_ff;
   logic [1:0]        rsp_status_ff;

   logic [RA_W-1:0]   row_idx;
   logic [RS_W-1:0]   rs_addr;
   logic [EA_W-1:0]   ent_addr;
   logic [RA_W-1:0]   vec_addr;
   logic [EP_W-1:0]   clamp_start;
   logic signed [ACC_W:0] acc_sum;
   logic signed [ACC_W-1:0] acc_sat;
   logic signed [ACC_W-1:0] acc_shift;
   logic [DATA_W-1:0] sat_res;
   logic              is_sub;
   logic              out_free;

   assign row_idx  = item_ff.position[RA_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;

   // row start load clamp
   always_comb begin
      if (work_item.data_word[DATA_W-1])
         clamp_start = '0;
      else if (work_item.data_word > 32'(MAX_ENTRIES))
         clamp_start = EP_W'(MAX_ENTRIES);
      else
         clamp_start = work_item.data_word[EP_W-1:0];
   end

   // read addresses chosen by the sequencer
   always_comb begin
      rs_addr  = (state_ff == ST_IDLE) ? RS_W'(work_item.position[RA_W-1:0]) :
                 RS_W'({1'b0, row_idx}) + 1'b1;
      ent_addr = (state_ff == ST_DIAG) ? begin_ff[EA_W-1:0] : k_ff[EA_W-1:0];
      vec_addr = (state_ff == ST_VREAD && !(k_ff == begin_ff && !use_ff)) ?
                 col_rd_ff[RA_W-1:0] : row_idx;
   end

   // saturating accumulate
   assign is_sub  = (item_ff.action != ACT_MULTIPLY);
   assign acc_sum = is_sub ? ({acc_ff[ACC_W-1], acc_ff} - {prod_ff[ACC_W-1], prod_ff}) :
                             ({acc_ff[ACC_W-1], acc_ff} + {prod_ff[ACC_W-1], prod_ff});
   always_comb begin
      if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
         acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      else
         acc_sat = acc_sum[ACC_W-1:0];
   end

   // floor shift then saturate to 32 bits
   assign acc_shift = acc_ff >>> FRAC_BITS;
   always_comb begin
      if (acc_shift > 64'sh7fff_ffff)
         sat_res = 32'h7fff_ffff;
      else if (acc_shift < -64'sh8000_0000)
         sat_res = 32'h8000_0000;
      else
         sat_res = acc_shift[DATA_W-1:0];
   end

   srk_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_num_ff),
      .divisor  (div_den_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign work_ready = (state_ff == ST_IDLE);

   // memory reads, registered
   always_ff @(posedge clock) begin
      rs_rd_ff  <= row_start_mem[rs_addr];
      col_rd_ff <= column_mem[ent_addr];
      val_rd_ff <= value_mem[ent_addr];
      vec_rd_ff <= vector_mem[vec_addr];
      rhs_rd_ff <= rhs_mem[row_idx];
   end

   // load writes and vector write back
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && work_valid) begin
         unique case (work_item.action)
            ACT_ROW_START: begin
               if (work_item.position <= POS_W'(MAX_ROWS))
                  row_start_mem[work_item.position[RS_W-1:0]] <= clamp_start;
            end
            ACT_ENTRY: begin
               if (32'(work_item.position) < 32'(MAX_ENTRIES)) begin
                  column_mem[work_item.position[EA_W-1:0]] <= work_item.column;
                  value_mem[work_item.position[EA_W-1:0]]  <= work_item.data_word;
               end
            end
            ACT_VECTOR: begin
               if (32'(work_item.position) < 32'(MAX_ROWS))
                  vector_mem[work_item.position[RA_W-1:0]] <= work_item.data_word;
            end
            ACT_RHS: begin
               if (32'(work_item.position) < 32'(MAX_ROWS))
                  rhs_mem[work_item.position[RA_W-1:0]] <= work_item.data_word;
            end
            default: ;
         endcase
      end
      if (state_ff == ST_WRITE)
         vector_mem[row_idx] <= div_q;
   end

   // row sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         div_start_ff  <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         // result beat: loaded from the pending result once the register is free
         if (state_ff == ST_OUT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready)                 rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (work_valid) begin
                  item_ff <= work_item;
                  if (work_item.action >= ACT_MULTIPLY && work_item.action <= ACT_READ_VEC) begin
                     if (!work_item.in_range) begin
                        res_value_ff  <= '0;
                        res_status_ff <= STATUS_RANGE;
                        state_ff      <= ST_OUT;
                     end else begin
                        state_ff <= ST_BEGIN;
                     end
                  end
               end
            end
            ST_BEGIN: begin
               begin_ff <= (rs_rd_ff > EP_W'(MAX_ENTRIES)) ? EP_W'(MAX_ENTRIES) : rs_rd_ff;
               state_ff <= ST_END;
            end
            ST_END: begin
               end_ff   <= (rs_rd_ff > EP_W'(MAX_ENTRIES)) ? EP_W'(MAX_ENTRIES) : rs_rd_ff;
               state_ff <= ST_DIAG;
            end
            ST_DIAG: begin
               // value and vector element of row r now being read
               if (end_ff < begin_ff) end_ff <= begin_ff;
               state_ff <= ST_PREP;
            end
            ST_PREP: begin
               xr_ff   <= vec_rd_ff;
               diag_ff <= (end_ff > begin_ff) ? val_rd_ff : '0;
               use_ff  <= 1'b0;
               if (item_ff.action == ACT_RESIDUAL)
                  acc_ff <= ACC_W'($signed(rhs_rd_ff)) <<< FRAC_BITS;
               else if (item_ff.action == ACT_MULTIPLY)
                  acc_ff <= '0;
               else
                  acc_ff <= ACC_W'($signed(vec_rd_ff)) <<< FRAC_BITS;
               if (item_ff.action == ACT_READ_VEC) begin
                  res_value_ff  <= vec_rd_ff;
                  res_status_ff <= STATUS_OK;
                  state_ff      <= ST_OUT;
               end else if (item_ff.action >= ACT_FWD_GS &&
                            !(end_ff > begin_ff && val_rd_ff != '0)) begin
                  res_value_ff  <= vec_rd_ff;
                  res_status_ff <= STATUS_ZERO_DIAG;
                  state_ff      <= ST_OUT;
               end else if (item_ff.action == ACT_JACOBI) begin
                  state_ff <= ST_DIV_MUL;
               end else begin
                  k_ff     <= (item_ff.action >= ACT_FWD_GS) ? begin_ff + 1'b1 : begin_ff;
                  state_ff <= ST_FETCH;
               end
            end
            ST_FETCH: begin
               // entry k read issued
               if (k_ff >= end_ff) state_ff <= ST_FINISH;
               else                state_ff <= ST_VREAD;
            end
            ST_VREAD: begin
               coef_ff <= val_rd_ff;
               if (k_ff == begin_ff) begin
                  use_ff    <= 1'b1;
                  col_ok_ff <= 1'b1;
               end else begin
                  col_ok_ff <= (32'(col_rd_ff) < 32'(MAX_ROWS));
                  if (item_ff.action == ACT_FWD_GS)
                     use_ff <= (ROW_W'(col_rd_ff) < item_ff.position[ROW_W-1:0]) ||
                               (item_ff.position[POS_W-1:ROW_W] != '0);
                  else if (item_ff.action == ACT_BWD_GS)
                     use_ff <= (32'(col_rd_ff) > 32'(item_ff.position));
                  else
                     use_ff <= 1'b1;
               end
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               prod_ff  <= (use_ff && col_ok_ff) ?
                           ACC_W'($signed(coef_ff)) * ACC_W'($signed(vec_rd_ff)) : '0;
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               if (use_ff) acc_ff <= acc_sat;
               use_ff   <= 1'b1;
               k_ff     <= k_ff + 1'b1;
               state_ff <= ST_FETCH;
            end
            ST_FINISH: begin
               if (item_ff.action <= ACT_RESIDUAL) begin
                  res_value_ff  <= sat_res;
                  res_status_ff <= STATUS_OK;
                  state_ff      <= ST_OUT;
               end else begin
                  div_num_ff   <= acc_ff;
                  div_den_ff   <= ACC_W'($signed(diag_ff));
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_DIV;
               end
            end
            ST_DIV_MUL: begin
               div_num_ff   <= ACC_W'($signed(xr_ff)) * ACC_W'($signed({1'b0, OMEGA_RAW}));
               div_den_ff   <= ACC_W'($signed(diag_ff)) <<< (OMEGA_FRAC - FRAC_BITS);
               div_start_ff <= 1'b1;
               state_ff     <= ST_DIV;
            end
            ST_DIV: begin
               if (div_done) state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               res_value_ff  <= div_q;
               res_status_ff <= STATUS_OK;
               state_ff      <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_row_ff    <= item_ff.position[ROW_W-1:0];
                  rsp_value_ff  <= res_value_ff;
                  rsp_status_ff <= res_status_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_row          = rsp_row_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
endmodule

[hdl/sparse_row_kernel.sv]
// top level of the sparse row kernel: config register, front queue and back end
// Compressed-row sparse matrix engine. Load actions (row start, entry, vector,
// rhs) are written while the back end is idle. Multiply, residual and
// Gauss-Seidel actions walk their row one entry at a time (read, vector read,
// multiply, add per stored entry) between setup and wind-down; Gauss-Seidel
// and Jacobi add a 64-step restoring divide that holds the row until it ends.
// A two-beat queue in front lets loads be taken while a row is walked, and the
// result register holds a finished beat while the next item starts.
module sparse_row_kernel
   import srk_pkg::*;
#(
   parameter int MAX_ROWS    = 1024,
   parameter int MAX_ENTRIES = 8192,
   parameter int FRAC_BITS   = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CNT_W-1:0]     csr_write_data,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [ACTION_W-1:0]  req_action,
   input  logic [POS_W-1:0]     req_position,
   input  logic [COL_W-1:0]     req_column,
   input  logic [DATA_W-1:0]    req_data_word,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ROW_W-1:0]     rsp_row,
   output logic [DATA_W-1:0]    rsp_result_value,
   output logic [1:0]           rsp_status
);
   logic [CNT_W-1:0] row_count_ff;
   logic             work_valid, work_ready;
   work_type         work_item;

   // row count register
   always_ff @(posedge clock) begin
      if (reset) row_count_ff <= '0;
      else if (csr_write_enable) row_count_ff <= csr_write_data;
   end

   srk_front #(.MAX_ROWS(MAX_ROWS), .DEPTH(2)) u_front (
      .clock         (clock),
      .reset         (reset),
      .row_count     (row_count_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_action    (req_action),
      .req_position  (req_position),
      .req_column    (req_column),
      .req_data_word (req_data_word),
      .work_valid    (work_valid),
      .work_ready    (work_ready),
      .work_item     (work_item)
   );

   srk_back #(.MAX_ROWS(MAX_ROWS), .MAX_ENTRIES(MAX_ENTRIES), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .work_valid       (work_valid),
      .work_ready       (work_ready),
      .work_item        (work_item),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_row          (rsp_row),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status)
   );

   // a result beat never carries an undefined status code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != 2'd3))
      else $error("bad status code");

   // a stalled result beat holds its value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> ($stable(rsp_result_value) && rsp_valid))
      else $error("result changed under stall");

   // out of range results carry zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_RANGE) |-> (rsp_result_value == '0))
      else $error("range error with nonzero value");
endmodule
